[hdl/pptt_pkg.sv]
package pptt_pkg;

  // Input operation codes.
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NOMATCH = 2'd2;

  // Result kinds.
  localparam logic KIND_FIRE    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // One input item.
  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] data_id;
    logic [63:0] period;
    logic [63:0] now_ns;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic        kind;
    logic [31:0] fired_id;
    logic [63:0] next_due_ns;
    logic        armed;
    logic [1:0]  status;
    logic        last;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // load a new input item
    logic adv;        // walk pipeline advances this cycle
    logic rd_en;      // table read is issued this cycle
    logic v_r;        // read stage holds an entry
    logic v_e1;       // first evaluate stage holds an entry
    logic v_e2;       // second evaluate stage holds an entry
    logic load_fire;  // load a fire result into the output register
    logic load_sum;   // load the summary result into the output register
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic e1_fire;    // first evaluate stage holds an entry that fires
  } dp_status_t;

endpackage

[hdl/pptt_ctrl.sv]
module pptt_ctrl #(
  parameter int MAX_TIMERS = 16,
  parameter int IdxW       = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  pptt_pkg::dp_status_t  sts_i,
  output pptt_pkg::ctl_cmd_t    cmd_o,
  output logic [IdxW-1:0]       rd_addr_o
);
  import pptt_pkg::*;

  localparam int CntW = $clog2(MAX_TIMERS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_SUM  = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            v_r_q, v_r_d, v_e1_q, v_e1_d, v_e2_q, v_e2_d;
  logic            out_valid_q, out_valid_d;
  logic            walking, issue, stall, adv, capture, load_fire, load_sum, pipe_empty;

  // Handshake and pipeline control.
  always_comb begin
    walking    = (state_q == S_WALK);
    issue      = walking && (cnt_q < CntW'(MAX_TIMERS));
    stall      = v_e1_q && sts_i.e1_fire && out_valid_q && !out_ready_i;
    adv        = walking && !stall;
    capture    = (state_q == S_IDLE) && in_valid_i;
    load_fire  = adv && v_e1_q && sts_i.e1_fire;
    load_sum   = (state_q == S_SUM) && (!out_valid_q || out_ready_i);
    pipe_empty = !issue && !v_r_q && !v_e1_q && !v_e2_q;
  end

  // Next state, walk counter and stage valid flags.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    v_r_d   = v_r_q;
    v_e1_d  = v_e1_q;
    v_e2_d  = v_e2_q;
    case (state_q)
      S_IDLE: begin
        if (capture) begin
          state_d = S_WALK;
          cnt_d   = '0;
        end
      end
      S_WALK: begin
        if (pipe_empty) begin
          state_d = S_SUM;
        end else if (adv) begin
          cnt_d  = issue ? cnt_q + CntW'(1) : cnt_q;
          v_r_d  = issue;
          v_e1_d = v_r_q;
          v_e2_d = v_e1_q;
        end
      end
      S_SUM: begin
        if (load_sum) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    out_valid_d = load_fire || load_sum || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      v_r_q       <= 1'b0;
      v_e1_q      <= 1'b0;
      v_e2_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      v_r_q       <= v_r_d;
      v_e1_q      <= v_e1_d;
      v_e2_q      <= v_e2_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Outputs to the ports and the datapath.
  always_comb begin
    in_ready_o        = (state_q == S_IDLE);
    out_valid_o       = out_valid_q;
    rd_addr_o         = cnt_q[IdxW-1:0];
    cmd_o.capture     = capture;
    cmd_o.adv         = adv;
    cmd_o.rd_en       = issue && adv;
    cmd_o.v_r         = v_r_q;
    cmd_o.v_e1        = v_e1_q;
    cmd_o.v_e2        = v_e2_q;
    cmd_o.load_fire   = load_fire;
    cmd_o.load_sum    = load_sum;
  end

endmodule

[hdl/pptt_datapath.sv]
module pptt_datapath #(
  parameter int MAX_TIMERS = 16,
  parameter int IdxW       = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pptt_pkg::ctl_cmd_t    cmd_i,
  input  logic [IdxW-1:0]       rd_addr_i,
  input  pptt_pkg::in_item_t    in_item_i,
  output pptt_pkg::dp_status_t  sts_o,
  output pptt_pkg::out_item_t   out_item_o
);
  import pptt_pkg::*;

  typedef struct packed {
    logic [31:0] id;
    logic [63:0] period;
    logic [63:0] countdown;
  } entry_t;

  // Timer table storage and valid bits.
  entry_t                mem_q [MAX_TIMERS];
  logic [MAX_TIMERS-1:0] valid_q;
  logic [63:0]           last_tick_q;

  // Current item.
  logic [1:0]  op_q;
  logic [31:0] id_q;
  logic [63:0] per_q;
  logic        per_nz_q;
  logic [63:0] elapsed_q;
  logic        placed_q, removed_q, any_q;
  logic [63:0] min_q;

  // Read stage.
  entry_t          r_ent_q;
  logic [IdxW-1:0] r_idx_q;

  // First evaluate stage.
  logic [IdxW-1:0] a_idx_q;
  logic [31:0]     a_id_q;
  logic [63:0]     a_per_q, a_cd_q, a_diff_q;
  logic            a_fire_q, a_vld_q, a_place_q, a_match_q;

  // Second evaluate stage.
  logic [63:0] b_val_q;
  logic        b_inc_q;

  out_item_t out_q;

  logic        is_tick, is_add, is_rem;
  logic        r_vld, place, match, fire;
  logic [64:0] diff65, reload65;
  logic [63:0] reload, dec, new_cd;
  logic        cd_upd, wr_en;
  logic [1:0]  status;

  assign is_tick = (op_q == OP_TICK);
  assign is_add  = (op_q == OP_ADD);
  assign is_rem  = (op_q == OP_REMOVE);

  // Read stage decisions: elapsed compare, free slot and remove match.
  always_comb begin
    r_vld  = valid_q[r_idx_q];
    diff65 = {1'b0, elapsed_q} - {1'b0, r_ent_q.countdown};
    place  = is_add && per_nz_q && !r_vld && !placed_q;
    match  = is_rem && per_nz_q && r_vld && !removed_q &&
             (r_ent_q.id == id_q) && (r_ent_q.period == per_q);
    fire   = is_tick && r_vld && !diff65[64];
  end

  // First evaluate stage: load the period on add, reload on fire, otherwise count down.
  always_comb begin
    reload65 = {1'b0, a_per_q} - {1'b0, a_diff_q};
    reload   = reload65[64] ? '0 : reload65[63:0];
    dec      = 64'd0 - a_diff_q;
    cd_upd   = (is_tick && a_vld_q) || a_place_q;
    if (a_place_q) begin
      new_cd = a_per_q;
    end else if (a_fire_q) begin
      new_cd = reload;
    end else begin
      new_cd = dec;
    end
    wr_en = cmd_i.adv && cmd_i.v_e1 && cd_upd;
  end

  // Status of the current item at summary time.
  always_comb begin
    if (is_add && per_nz_q && !placed_q) begin
      status = ST_FULL;
    end else if (is_rem && per_nz_q && !removed_q) begin
      status = ST_NOMATCH;
    end else begin
      status = ST_OK;
    end
  end

  // Table memory: one read and one write per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      r_ent_q <= mem_q[rd_addr_i];
    end
    if (wr_en) begin
      mem_q[a_idx_q] <= '{id: a_id_q, period: a_per_q, countdown: new_cd};
    end
  end

  // Valid bits and the time of the last tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      last_tick_q <= '0;
    end else begin
      if (cmd_i.capture && (in_item_i.op == OP_TICK)) begin
        last_tick_q <= in_item_i.now_ns;
      end
      if (cmd_i.adv && cmd_i.v_r) begin
        if (place) begin
          valid_q[r_idx_q] <= 1'b1;
        end else if (match) begin
          valid_q[r_idx_q] <= 1'b0;
        end
      end
    end
  end

  // Item registers, walk stages, minimum tracking and result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q      <= in_item_i.op;
      id_q      <= in_item_i.data_id;
      per_q     <= in_item_i.period;
      per_nz_q  <= (in_item_i.period != 64'd0);
      elapsed_q <= in_item_i.now_ns - last_tick_q;
      placed_q  <= 1'b0;
      removed_q <= 1'b0;
      any_q     <= 1'b0;
      min_q     <= '1;
    end
    if (cmd_i.rd_en) begin
      r_idx_q <= rd_addr_i;
    end
    if (cmd_i.adv && cmd_i.v_r) begin
      if (place) begin
        placed_q <= 1'b1;
      end
      if (match) begin
        removed_q <= 1'b1;
      end
    end
    if (cmd_i.adv) begin
      a_idx_q   <= r_idx_q;
      a_id_q    <= place ? id_q : r_ent_q.id;
      a_per_q   <= place ? per_q : r_ent_q.period;
      a_cd_q    <= r_ent_q.countdown;
      a_diff_q  <= diff65[63:0];
      a_fire_q  <= cmd_i.v_r && fire;
      a_vld_q   <= r_vld;
      a_place_q <= place;
      a_match_q <= match;
      b_val_q   <= cd_upd ? new_cd : a_cd_q;
      b_inc_q   <= (a_vld_q && !a_match_q) || a_place_q;
    end
    if (cmd_i.adv && cmd_i.v_e2 && b_inc_q) begin
      any_q <= 1'b1;
      if (b_val_q < min_q) begin
        min_q <= b_val_q;
      end
    end
    if (cmd_i.load_fire) begin
      out_q <= '{kind: KIND_FIRE, fired_id: a_id_q, next_due_ns: 64'd0,
                 armed: 1'b0, status: ST_OK, last: 1'b0};
    end else if (cmd_i.load_sum) begin
      out_q <= '{kind: KIND_SUMMARY, fired_id: 32'd0, next_due_ns: min_q,
                 armed: any_q, status: status, last: 1'b1};
    end
  end

  assign sts_o.e1_fire = a_fire_q;
  assign out_item_o    = out_q;

endmodule

[hdl/periodic_pull_timer_table_unit.sv]
// Periodic pull timer table. Holds up to MAX_TIMERS timers (id, period,
// countdown) in a table memory with one read and one write port plus a row
// of valid flops, so no clearing pass is needed after reset. Every item (tick,
// add or remove) walks the whole table one entry per cycle, pausing while a
// fire result cannot enter the full output register, through a three-stage
// pipeline (read, evaluate, minimum). Fire results come out in ascending slot
// order, and each item ends with one summary result marked last. The input is
// taken only while the block is idle; the output register lets the summary
// wait for the consumer while the next item is already accepted.
module periodic_pull_timer_table_unit #(
  parameter int MAX_TIMERS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  pptt_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output pptt_pkg::out_item_t  out_item_o
);
  import pptt_pkg::*;

  localparam int IdxW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;

  ctl_cmd_t        cmd;
  dp_status_t      sts;
  logic [IdxW-1:0] rd_addr;

  // Sequencer for the table walk and the result handshake.
  pptt_ctrl #(
    .MAX_TIMERS(MAX_TIMERS),
    .IdxW      (IdxW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .rd_addr_o  (rd_addr)
  );

  // Table storage and per-entry arithmetic.
  pptt_datapath #(
    .MAX_TIMERS(MAX_TIMERS),
    .IdxW      (IdxW)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .rd_addr_i (rd_addr),
    .in_item_i (in_item_i),
    .sts_o     (sts),
    .out_item_o(out_item_o)
  );

endmodule

[hdl/pptt_checker.sv]
module pptt_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input pptt_pkg::in_item_t   in_item_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input pptt_pkg::out_item_t  out_item_o
);
  import pptt_pkg::*;

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // After a transfer in, the block is busy with that item.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken twice in a row");

  // Fire results carry only the id and are never the last result.
  a_fire_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.kind == KIND_FIRE) |->
      !out_item_o.last && (out_item_o.status == ST_OK) && !out_item_o.armed)
    else $error("malformed fire result");

  // An empty table reports an all-ones timeout.
  a_empty_summary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.kind == KIND_SUMMARY) && !out_item_o.armed |->
      (out_item_o.next_due_ns == '1) && out_item_o.last)
    else $error("empty summary with finite timeout");

  // While idle, only a summary can still be waiting at the output.
  a_idle_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o && out_valid_o |-> out_item_o.last)
    else $error("fire result pending while idle");

endmodule

bind periodic_pull_timer_table_unit pptt_checker u_pptt_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_item_i  (in_item_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_item_o (out_item_o)
);

[sim/timer_table_checker.sv]
`timescale 1ns / 100ps

module timer_table_checker
  import pptt_pkg::*;
#(
  parameter int MAX_TIMERS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_item_t    in_item_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_item_t   out_item_i,
  output int unsigned errors_o,
  output int unsigned pending_o
);

  // Shadow copy of the timer table, cleared as after reset.
  logic        timer_valid     [MAX_TIMERS] = '{default: 1'b0};
  logic [31:0] timer_id        [MAX_TIMERS] = '{default: '0};
  logic [63:0] timer_countdown [MAX_TIMERS] = '{default: '0};
  logic [63:0] timer_period    [MAX_TIMERS] = '{default: '0};
  logic [63:0] prev_tick_ns = '0;

  // Fire and summary results still owed by the block, oldest first.
  out_item_t timer_results_q[$];

  initial begin
    errors_o  = 0;
    pending_o = 0;
  end

  // Applies one input item to the shadow table and queues the results it causes.
  task automatic advance_timer_table(input in_item_t it);
    logic [63:0] elapsed;
    logic [63:0] late;
    logic [63:0] min_cd;
    logic [1:0]  st;
    logic        any_on;
    logic        done;
    out_item_t   res;
    st   = ST_OK;
    done = 1'b0;
    case (it.op)
      OP_TICK: begin
        // Elapsed time wraps like a plain subtractor when time runs backwards.
        elapsed      = it.now_ns - prev_tick_ns;
        prev_tick_ns = it.now_ns;
        for (int i = 0; i < MAX_TIMERS; i++) begin
          if (timer_valid[i]) begin
            if (elapsed >= timer_countdown[i]) begin
              late                 = elapsed - timer_countdown[i];
              res                  = '0;
              res.kind             = KIND_FIRE;
              res.fired_id         = timer_id[i];
              res.status           = ST_OK;
              timer_results_q.push_back(res);
              timer_countdown[i] = (late >= timer_period[i]) ? '0 : timer_period[i] - late;
            end else begin
              timer_countdown[i] = timer_countdown[i] - elapsed;
            end
          end
        end
      end
      OP_ADD: begin
        // A zero period stores nothing; otherwise take the lowest free slot.
        if (it.period != '0) begin
          st = ST_FULL;
          for (int i = 0; i < MAX_TIMERS; i++) begin
            if (!done && !timer_valid[i]) begin
              timer_valid[i]     = 1'b1;
              timer_id[i]        = it.data_id;
              timer_period[i]    = it.period;
              timer_countdown[i] = it.period;
              st                 = ST_OK;
              done               = 1'b1;
            end
          end
        end
      end
      OP_REMOVE: begin
        // Only the lowest matching slot goes away.
        if (it.period != '0) begin
          st = ST_NOMATCH;
          for (int i = 0; i < MAX_TIMERS; i++) begin
            if (!done && timer_valid[i] && timer_id[i] == it.data_id &&
                timer_period[i] == it.period) begin
              timer_valid[i] = 1'b0;
              st             = ST_OK;
              done           = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase

    // Every item ends with the summary of the table as it now stands.
    min_cd = '1;
    any_on = 1'b0;
    for (int i = 0; i < MAX_TIMERS; i++) begin
      if (timer_valid[i]) begin
        any_on = 1'b1;
        if (timer_countdown[i] < min_cd) min_cd = timer_countdown[i];
      end
    end
    res             = '0;
    res.kind        = KIND_SUMMARY;
    res.next_due_ns = min_cd;
    res.armed       = any_on;
    res.status      = st;
    res.last        = 1'b1;
    timer_results_q.push_back(res);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors_o++;
    end
  endtask

  // Watch both channels; results are checked before the new input is predicted.
  always @(posedge clk_i) begin : watch_channels
    out_item_t want;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (timer_results_q.size() == 0) begin
          $error("result transfer with no result pending");
          errors_o++;
        end else begin
          want = timer_results_q.pop_front();
          check_field("kind", 64'(want.kind), 64'(out_item_i.kind));
          check_field("fired_id", 64'(want.fired_id), 64'(out_item_i.fired_id));
          check_field("next_due_ns", want.next_due_ns, out_item_i.next_due_ns);
          check_field("armed", 64'(want.armed), 64'(out_item_i.armed));
          check_field("status", 64'(want.status), 64'(out_item_i.status));
          check_field("last", 64'(want.last), 64'(out_item_i.last));
        end
      end
      if (in_valid_i && in_ready_i) advance_timer_table(in_item_i);
      pending_o = timer_results_q.size();
    end
  end

endmodule

[sim/tb_periodic_pull_timer_table_unit.sv]
`timescale 1ns / 100ps

module tb_periodic_pull_timer_table_unit;
  import pptt_pkg::*;

  localparam int MAX_TIMERS = 16;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int PHASE_ITEMS = 75;
  localparam int SETTLE_CYCLES = 4 * MAX_TIMERS;
  localparam longint LIMIT_NS = 5_000_000;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      out_ready_i = 1'b0;
  in_item_t  in_item_i   = '0;
  logic      in_ready_o;
  logic      out_valid_o;
  out_item_t out_item_o;

  int unsigned errors;
  int unsigned pending;
  int          send_idle_pct = 24;
  int          recv_idle_pct = 60;

  // Stimulus bookkeeping: time of the latest tick and timers added so far.
  logic [63:0] tick_ns = '0;
  logic [31:0] added_ids[$];
  logic [63:0] added_periods[$];

  periodic_pull_timer_table_unit #(
    .MAX_TIMERS(MAX_TIMERS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  timer_table_checker #(
    .MAX_TIMERS(MAX_TIMERS)
  ) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_i (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_i(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_i (out_item_o),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // The result side stalls at random, at the rate of the current phase.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    #(LIMIT_NS);
    $display("tb_periodic_pull_timer_table_unit NOT OK");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic in_item_t make_item(input logic [1:0] op, input logic [31:0] id,
                                         input logic [63:0] period,
                                         input logic [63:0] now);
    in_item_t it;
    it.op      = op;
    it.data_id = id;
    it.period  = period;
    it.now_ns  = now;
    return it;
  endfunction

  // Mostly small periods and short tick steps so timers fire often; fields the
  // operation ignores carry random bits.
  function automatic in_item_t random_item();
    in_item_t it;
    int       sel;
    int       pick;
    it  = make_item(OP_TICK, $urandom(), rand64(), rand64());
    sel = $urandom_range(99);
    if (sel < 40) begin
      pick = $urandom_range(19);
      if (pick == 0) it.now_ns = rand64();
      else if (pick == 1) it.now_ns = tick_ns - 64'($urandom_range(100));
      else it.now_ns = tick_ns + 64'($urandom_range(250));
      tick_ns = it.now_ns;
    end else if (sel < 68) begin
      it.op      = OP_ADD;
      it.data_id = ($urandom_range(99) < 85) ? $urandom_range(7) : $urandom();
      pick       = $urandom_range(19);
      if (pick == 0) it.period = '0;
      else if (pick == 1) it.period = rand64();
      else it.period = 64'($urandom_range(300, 1));
      added_ids.push_back(it.data_id);
      added_periods.push_back(it.period);
      if (added_ids.size() > 32) begin
        void'(added_ids.pop_front());
        void'(added_periods.pop_front());
      end
    end else if (sel < 95) begin
      it.op = OP_REMOVE;
      if (added_ids.size() != 0 && $urandom_range(99) < 75) begin
        pick       = $urandom_range(added_ids.size() - 1);
        it.data_id = added_ids[pick];
        it.period  = added_periods[pick];
      end else begin
        it.data_id = $urandom_range(7);
        it.period  = 64'($urandom_range(300));
      end
    end else begin
      it.op = OP_UNUSED;
    end
    return it;
  endfunction

  // Offers one item and holds it until the transfer happens.
  task automatic send_item(input in_item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty table, zero periods, extremes, duplicates, misses,
    // unused code, time running backwards, and a full table.
    send_item(make_item(OP_TICK, '0, '0, '0));
    send_item(make_item(OP_ADD, '0, '0, '1));
    send_item(make_item(OP_ADD, '1, '1, '0));
    send_item(make_item(OP_ADD, 32'd5, 64'd100, '0));
    send_item(make_item(OP_ADD, 32'd5, 64'd100, '0));
    send_item(make_item(OP_REMOVE, 32'd5, '0, '0));
    send_item(make_item(OP_REMOVE, 32'd7, 64'd100, '0));
    send_item(make_item(OP_UNUSED, '1, '1, '1));
    send_item(make_item(OP_TICK, '0, '0, 64'd150));
    send_item(make_item(OP_TICK, '0, '0, 64'd100));
    send_item(make_item(OP_REMOVE, 32'd5, 64'd100, '0));
    for (int i = 0; i < MAX_TIMERS - 1; i++) begin
      send_item(make_item(OP_ADD, $urandom(), 64'($urandom_range(500, 1)), rand64()));
    end
    send_item(make_item(OP_TICK, '0, '0, 64'd1000));
    tick_ns = 64'd1000;

    // Random part in three idling phases.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 24;
          recv_idle_pct = 60;
        end
        1: begin
          send_idle_pct = 60;
          recv_idle_pct = 24;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) send_item(random_item());
    end
    in_valid_i <= 1'b0;

    // Drain the owed results, then watch for strays.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_periodic_pull_timer_table_unit OK");
    end else begin
      $display("tb_periodic_pull_timer_table_unit NOT OK");
    end
    $finish;
  end

endmodule

[files.f]
hdl/pptt_pkg.sv
hdl/pptt_ctrl.sv
hdl/pptt_datapath.sv
hdl/periodic_pull_timer_table_unit.sv
hdl/pptt_checker.sv
sim/timer_table_checker.sv
sim/tb_periodic_pull_timer_table_unit.sv
